/* rtl/rpf_pkg.sv */
// Types, constants and helpers shared by the reordering packet FIFO.
package rpf_pkg;

  localparam int unsigned LenW    = 16;
  localparam int unsigned TagW    = 32;
  localparam int unsigned BytesW  = 24;
  localparam int unsigned CntW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 24;

  localparam logic [CfgIdxW-1:0] CFG_LIMIT_IN_BYTES     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SIZE           = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REORDER_DEPTH      = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_IN_SEQUENCE_LENGTH = 2'd3;

  localparam logic [BytesW-1:0] MAX_SIZE_RST       = 24'd100;
  localparam logic [CntW-1:0]   REORDER_DEPTH_RST  = 8'd3;
  localparam logic [CntW-1:0]   IN_SEQ_LENGTH_RST  = 8'd10;
  localparam logic [CntW-1:0]   CNT_MAX            = 8'hFF;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED  = 2'd0,
    STATUS_DROPPED   = 2'd1,
    STATUS_DELIVERED = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    STATE_IDLE,
    STATE_EXEC,
    STATE_SECOND
  } state_e;

  typedef struct packed {
    op_e             op;
    logic [TagW-1:0] packet_tag;
    logic [LenW-1:0] packet_bytes;
  } in_item_t;

  typedef struct packed {
    status_e         status;
    logic [TagW-1:0] out_tag;
    logic [LenW-1:0] out_bytes;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } result_t;

  function automatic logic [CntW-1:0] sat_inc(logic [CntW-1:0] c);
    return (c == CNT_MAX) ? c : c + 8'd1;
  endfunction

endpackage

/* rtl/rpf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rpf_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rpf_ctrl.sv */
// Sequencer: configuration, pointers, counters, hold register and store access.
module rpf_ctrl #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_BITS    = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rpf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpf_pkg::CfgW-1:0]   cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rpf_pkg::in_item_t          in_data_i,
  input  logic                       out_free_i,
  output rpf_pkg::result_t           res_o
);

  localparam int unsigned PtrW  = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned DescW = TAG_BITS + rpf_pkg::LenW;
  localparam int unsigned LenW  = rpf_pkg::LenW;
  localparam int unsigned BytesW = rpf_pkg::BytesW;

  rpf_pkg::state_e state_q, state_d;
  rpf_pkg::in_item_t req_q, req_d;

  logic                      limit_in_bytes_q;
  logic [BytesW-1:0]         max_size_q;
  logic [rpf_pkg::CntW-1:0]  reorder_depth_q;
  logic [rpf_pkg::CntW-1:0]  in_seq_length_q;

  logic [PtrW-1:0]           head_q, head_d, tail_q, tail_d, head_inc, tail_inc;
  logic [CntW-1:0]           count_q, count_d;
  logic [BytesW-1:0]         bytes_q, bytes_d;
  logic                      held_q, held_d;
  logic [DescW-1:0]          held_desc_q, held_desc_d;
  logic [rpf_pkg::CntW-1:0]  bypass_q, bypass_d, in_order_q, in_order_d;

  logic                      ram_we, ram_re;
  logic [PtrW-1:0]           ram_raddr;
  logic [DescW-1:0]          ram_wdata, ram_rdata;
  logic [BytesW:0]           bytes_sum;
  logic                      drop;
  logic [LenW-1:0]           rd_len, held_len;
  rpf_pkg::result_t          res;

  rpf_ram #(
    .Width (DescW),
    .Depth (QUEUE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign head_inc  = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_inc  = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign ram_wdata = {TAG_BITS'(req_q.packet_tag), req_q.packet_bytes};
  assign rd_len    = ram_rdata[LenW-1:0];
  assign held_len  = held_desc_q[LenW-1:0];
  assign bytes_sum = {1'b0, bytes_q} + (BytesW + 1)'(req_q.packet_bytes);
  assign drop = (!limit_in_bytes_q && (BytesW'(count_q) >= max_size_q)) ||
                (limit_in_bytes_q && (bytes_sum >= {1'b0, max_size_q})) ||
                (count_q == CntW'(QUEUE_DEPTH));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_in_bytes_q <= 1'b0;
      max_size_q       <= rpf_pkg::MAX_SIZE_RST;
      reorder_depth_q  <= rpf_pkg::REORDER_DEPTH_RST;
      in_seq_length_q  <= rpf_pkg::IN_SEQ_LENGTH_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rpf_pkg::CFG_LIMIT_IN_BYTES:     limit_in_bytes_q <= cfg_data_i[0];
        rpf_pkg::CFG_MAX_SIZE:           max_size_q       <= cfg_data_i;
        rpf_pkg::CFG_REORDER_DEPTH:      reorder_depth_q  <= cfg_data_i[7:0];
        rpf_pkg::CFG_IN_SEQUENCE_LENGTH: in_seq_length_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rpf_pkg::STATE_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      count_q    <= '0;
      bytes_q    <= '0;
      held_q     <= 1'b0;
      bypass_q   <= '0;
      in_order_q <= '0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      bytes_q    <= bytes_d;
      held_q     <= held_d;
      bypass_q   <= bypass_d;
      in_order_q <= in_order_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    held_desc_q <= held_desc_d;
  end

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    bytes_d     = bytes_q;
    held_d      = held_q;
    held_desc_d = held_desc_q;
    bypass_d    = bypass_q;
    in_order_d  = in_order_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = head_q;
    in_ready_o  = 1'b0;
    res         = '0;

    case (state_q)
      rpf_pkg::STATE_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          req_d   = in_data_i;
          ram_re  = (in_data_i.op == rpf_pkg::OP_DEQUEUE);
          state_d = rpf_pkg::STATE_EXEC;
        end
      end
      rpf_pkg::STATE_EXEC: begin
        if (out_free_i) begin
          state_d   = rpf_pkg::STATE_IDLE;
          res.valid = 1'b1;
          if (req_q.op == rpf_pkg::OP_ENQUEUE) begin
            if (drop) begin
              res.item.status = rpf_pkg::STATUS_DROPPED;
            end else begin
              ram_we          = 1'b1;
              tail_d          = tail_inc;
              count_d         = count_q + 1'b1;
              bytes_d         = bytes_sum[BytesW-1:0];
              res.item.status = rpf_pkg::STATUS_ENQUEUED;
            end
          end else if (count_q == '0) begin
            res.item.status = rpf_pkg::STATUS_EMPTY;
          end else if (held_q && (bypass_q >= reorder_depth_q)) begin
            held_d             = 1'b0;
            bytes_d            = bytes_q - BytesW'(held_len);
            in_order_d         = '0;
            bypass_d           = '0;
            res.item.status    = rpf_pkg::STATUS_DELIVERED;
            res.item.out_tag   = rpf_pkg::TagW'(held_desc_q[DescW-1:LenW]);
            res.item.out_bytes = held_len;
          end else if (!held_q && (in_order_q >= in_seq_length_q)) begin
            held_desc_d = ram_rdata;
            head_d      = head_inc;
            count_d     = count_q - 1'b1;
            in_order_d  = '0;
            bypass_d    = '0;
            if (count_q == CntW'(1)) begin
              bytes_d            = bytes_q - BytesW'(rd_len);
              res.item.status    = rpf_pkg::STATUS_DELIVERED;
              res.item.out_tag   = rpf_pkg::TagW'(ram_rdata[DescW-1:LenW]);
              res.item.out_bytes = rd_len;
            end else begin
              held_d    = 1'b1;
              ram_re    = 1'b1;
              ram_raddr = head_inc;
              res.valid = 1'b0;
              state_d   = rpf_pkg::STATE_SECOND;
            end
          end else begin
            head_d  = head_inc;
            count_d = count_q - 1'b1;
            bytes_d = bytes_q - BytesW'(rd_len);
            if (held_q) begin
              bypass_d = rpf_pkg::sat_inc(bypass_q);
            end else begin
              in_order_d = rpf_pkg::sat_inc(in_order_q);
            end
            res.item.status    = rpf_pkg::STATUS_DELIVERED;
            res.item.out_tag   = rpf_pkg::TagW'(ram_rdata[DescW-1:LenW]);
            res.item.out_bytes = rd_len;
          end
        end
      end
      rpf_pkg::STATE_SECOND: begin
        if (out_free_i) begin
          head_d             = head_inc;
          count_d            = count_q - 1'b1;
          bytes_d            = bytes_q - BytesW'(rd_len);
          bypass_d           = rpf_pkg::sat_inc(bypass_q);
          res.valid          = 1'b1;
          res.item.status    = rpf_pkg::STATUS_DELIVERED;
          res.item.out_tag   = rpf_pkg::TagW'(ram_rdata[DescW-1:LenW]);
          res.item.out_bytes = rd_len;
          state_d            = rpf_pkg::STATE_IDLE;
        end
      end
      default: state_d = rpf_pkg::STATE_IDLE;
    endcase
  end

  assign res_o = res;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("stored count above store depth");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("store read and written in one cycle");

  a_res_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> out_free_i)
    else $error("result issued while output register busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rpf_pkg::STATE_EXEC))
    else $error("accepted transaction not executed");

  a_second_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rpf_pkg::STATE_SECOND) |-> (held_q && count_q != '0))
    else $error("second pop without held packet");

endmodule

/* rtl/reordering_packet_fifo_core.sv */
// Top level of the reordering packet FIFO: sequencer and output register.
//
// channel  direction  handshake                 payload
// cfg      in         cfg_we_i                  cfg_index_i, cfg_data_i
// in       in         in_valid_i / in_ready_o   in_data_i  (rpf_pkg::in_item_t)
// out      out        out_valid_o / out_ready_i out_data_o (rpf_pkg::out_item_t)
//
// Enqueue and every dequeue go through the idle and execute states, except a
// dequeue that takes a hold with packets still queued behind it: that one
// also passes the second state, set by the single store read port.
// Reset clears pointers, counters and hold flag; the store needs no clearing.
// A result waits in the output register; the next transaction is accepted
// meanwhile and stalls in execution until the register frees.
module reordering_packet_fifo_core #(
  parameter int unsigned QUEUE_DEPTH = 128,
  parameter int unsigned TAG_BITS    = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rpf_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rpf_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  rpf_pkg::in_item_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output rpf_pkg::out_item_t          out_data_o
);

  logic               out_valid_q, out_valid_d;
  rpf_pkg::out_item_t out_data_q, out_data_d;
  logic               out_free;
  rpf_pkg::result_t   res;

  rpf_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_free_i  (out_free),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
      out_data_d  = res.item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
